// File: rtl/ptlr_pkg.sv
// shared types and constants for the proportional text line renderer
// glyph and frame geometry, operation and panel command codes, port structs
// no dependencies
package ptlr_pkg;

	localparam int GLYPH_COUNT   = 96;
	localparam int GLYPH_BYTES   = 25;
	localparam int PANEL_COLUMNS = 128;

	localparam int GLYPH_PAIRS = (GLYPH_BYTES - 1) / 2;
	localparam int GLYPH_READS = 1 + 2 * GLYPH_PAIRS;
	localparam int GLYPH_SIZE  = GLYPH_COUNT * GLYPH_BYTES;
	localparam int FRAME_SIZE  = 4 * PANEL_COLUMNS;
	localparam int PAGE_SLOTS  = 3 + PANEL_COLUMNS;

	localparam int GLYPH_AW = $clog2(GLYPH_SIZE);
	localparam int FRAME_AW = $clog2(FRAME_SIZE);
	localparam int SLOT_W   = $clog2(PAGE_SLOTS);
	localparam int RI_W     = $clog2(GLYPH_READS + 1);
	localparam int COL_W    = 8;

	localparam logic [7:0] FIRST_CODE = 8'h20;

	localparam logic [1:0] OP_FONT    = 2'd0;
	localparam logic [1:0] OP_DRAW    = 2'd1;
	localparam logic [1:0] OP_END     = 2'd2;
	localparam logic [1:0] OP_REFRESH = 2'd3;

	localparam logic [7:0] CMD_COL_LO = 8'h00;
	localparam logic [7:0] CMD_COL_HI = 8'h10;
	localparam logic [7:0] CMD_PAGE   = 8'hB0;

	typedef struct packed {
		logic [1:0]  operation;
		logic        text_line;
		logic [7:0]  char_code;
		logic [11:0] font_address;
		logic [7:0]  font_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       frame_end;
	} result_t;

	typedef struct packed {
		logic                is_data;
		logic                last;
		logic [7:0]          cmd;
		logic [FRAME_AW-1:0] faddr;
	} stream_info_t;

endpackage

// File: rtl/ptlr_stream.sv
// refresh stream position: page and slot counters, command bytes, frame address
// depends on ptlr_pkg
module ptlr_stream (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	output ptlr_pkg::stream_info_t info
);
	import ptlr_pkg::*;

	logic [1:0]        page_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= '0;
			slot_q <= '0;
		end else if (step) begin
			if (slot_q == SLOT_W'(PAGE_SLOTS - 1)) begin
				slot_q <= '0;
				page_q <= page_q + 2'd1;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	assign col = slot_q - SLOT_W'(3);

	always_comb begin
		info.is_data = (slot_q >= SLOT_W'(3));
		info.last    = (page_q == 2'd3) && (slot_q == SLOT_W'(PAGE_SLOTS - 1));
		info.faddr   = FRAME_AW'(int'(page_q) * PANEL_COLUMNS + int'(col));
		priority if (slot_q == SLOT_W'(0)) begin
			info.cmd = CMD_COL_LO;
		end else if (slot_q == SLOT_W'(1)) begin
			info.cmd = CMD_COL_HI;
		end else begin
			info.cmd = CMD_PAGE | {6'd0, page_q};
		end
	end

endmodule

// File: rtl/proportional_text_line_renderer.sv
// font write: taken while idle, busy stays low; draw: reads the glyph width, then its
// column bytes, one glyph store read and one frame store write a cycle; end line:
// clears the rest of the line; refresh step: busy, result strobed in the cycle after;
// one item at a time, busy high meanwhile; results cannot be stalled
// reset: asynchronous; a clearing pass of the frame store follows, busy high
// depends on ptlr_pkg, ptlr_stream
module proportional_text_line_renderer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ptlr_pkg::item_t   item,
	output logic              result_valid,
	output ptlr_pkg::result_t result
);
	import ptlr_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_DRAW_OFF, ST_DRAW_RUN, ST_END_RUN, ST_REF_READ, ST_REF_OUT
	} state_t;

	state_t              state_q;
	logic [FRAME_AW-1:0] clr_q;
	logic                line_q;
	logic [COL_W-1:0]    col_q;
	logic [7:0]          glyph_q;
	logic [GLYPH_AW-1:0] off_q;
	logic [RI_W-1:0]     rd_idx_q;
	logic                rd_v_s1;
	logic [RI_W-1:0]     rd_idx_s1;
	logic [COL_W-1:0]    pair_q;
	logic                half_q;
	logic [7:0]          width_q;
	logic [COL_W-1:0]    upper_col_q;
	logic [COL_W-1:0]    lower_col_q;
	logic                result_valid_q;
	result_t             result_q;

	logic [7:0] glyph_mem [GLYPH_SIZE];
	logic [7:0] frame_mem [FRAME_SIZE];
	logic [7:0] glyph_rdata_s1;
	logic [7:0] frame_rdata_q;

	logic                accept;
	logic [8:0]          code_off;
	logic                code_ok;
	logic                gr_en;
	logic [GLYPH_AW-1:0] gr_addr;
	logic [COL_W:0]      fa_c;
	logic [FRAME_AW-1:0] fa_addr;
	logic                fw_en;
	logic [FRAME_AW-1:0] fw_addr;
	logic [7:0]          fw_data;
	logic [COL_W:0]      next_col;
	logic                last_rd;
	stream_info_t        sinfo;

	ptlr_stream u_stream (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (state_q == ST_REF_OUT),
		.info   (sinfo)
	);

	assign busy         = (state_q != ST_IDLE);
	assign accept       = start && !busy;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign code_off = {1'b0, item.char_code} - {1'b0, FIRST_CODE};
	assign code_ok  = (item.char_code >= FIRST_CODE) && (int'(code_off) < GLYPH_COUNT);

	assign gr_en   = (state_q == ST_DRAW_RUN) && (rd_idx_q < RI_W'(GLYPH_READS));
	assign gr_addr = off_q + GLYPH_AW'(rd_idx_q);
	assign last_rd = rd_v_s1 && (rd_idx_s1 == RI_W'(GLYPH_READS - 1));

	assign fa_c     = {1'b0, col_q} + {1'b0, pair_q};
	assign fa_addr  = FRAME_AW'((line_q ? 2 * PANEL_COLUMNS : 0)
		+ (half_q ? PANEL_COLUMNS : 0) + int'(fa_c));
	assign next_col = {1'b0, col_q} + {1'b0, width_q};

	always_comb begin
		fw_en   = 1'b0;
		fw_addr = fa_addr;
		fw_data = 8'd0;
		unique case (state_q)
			ST_CLEAR: begin
				fw_en   = 1'b1;
				fw_addr = clr_q;
			end
			ST_DRAW_RUN: begin
				fw_en   = rd_v_s1 && (rd_idx_s1 != '0) && (int'(fa_c) < PANEL_COLUMNS);
				fw_data = glyph_rdata_s1;
			end
			ST_END_RUN: begin
				fw_en = (int'(col_q) < PANEL_COLUMNS);
			end
			default: begin
				fw_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && item.operation == OP_FONT && int'(item.font_address) < GLYPH_SIZE) begin
			glyph_mem[GLYPH_AW'(item.font_address)] <= item.font_byte;
		end
		if (gr_en) begin
			glyph_rdata_s1 <= glyph_mem[gr_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (fw_en) begin
			frame_mem[fw_addr] <= fw_data;
		end
		if (state_q == ST_REF_READ) begin
			frame_rdata_q <= frame_mem[sinfo.faddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			line_q         <= 1'b0;
			col_q          <= '0;
			glyph_q        <= '0;
			off_q          <= '0;
			rd_idx_q       <= '0;
			rd_v_s1        <= 1'b0;
			rd_idx_s1      <= '0;
			pair_q         <= '0;
			half_q         <= 1'b0;
			width_q        <= '0;
			upper_col_q    <= '0;
			lower_col_q    <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= (state_q == ST_REF_OUT);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == FRAME_AW'(FRAME_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						line_q  <= item.text_line;
						col_q   <= item.text_line ? lower_col_q : upper_col_q;
						glyph_q <= code_off[7:0];
						pair_q  <= '0;
						half_q  <= 1'b0;
						unique case (item.operation)
							OP_FONT: state_q <= ST_IDLE;
							OP_DRAW: state_q <= code_ok ? ST_DRAW_OFF : ST_IDLE;
							OP_END: state_q <= ST_END_RUN;
							OP_REFRESH: state_q <= ST_REF_READ;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DRAW_OFF: begin
					off_q    <= GLYPH_AW'(int'(glyph_q) * GLYPH_BYTES);
					rd_idx_q <= '0;
					rd_v_s1  <= 1'b0;
					state_q  <= ST_DRAW_RUN;
				end
				ST_DRAW_RUN: begin
					rd_v_s1   <= gr_en;
					rd_idx_s1 <= rd_idx_q;
					if (gr_en) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (rd_v_s1) begin
						if (rd_idx_s1 == '0) begin
							width_q <= glyph_rdata_s1;
						end else begin
							half_q <= ~half_q;
							if (half_q) begin
								pair_q <= pair_q + 1'b1;
							end
						end
					end
					if (last_rd) begin
						if (int'(next_col) > PANEL_COLUMNS) begin
							if (line_q) lower_col_q <= COL_W'(PANEL_COLUMNS);
							else upper_col_q <= COL_W'(PANEL_COLUMNS);
						end else begin
							if (line_q) lower_col_q <= next_col[COL_W-1:0];
							else upper_col_q <= next_col[COL_W-1:0];
						end
						state_q <= ST_IDLE;
					end
				end
				ST_END_RUN: begin
					if (int'(col_q) < PANEL_COLUMNS) begin
						half_q <= ~half_q;
						if (half_q) begin
							col_q <= col_q + 1'b1;
						end
					end else begin
						if (line_q) lower_col_q <= '0;
						else upper_col_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_REF_READ: begin
					state_q <= ST_REF_OUT;
				end
				ST_REF_OUT: begin
					result_q.out_byte  <= sinfo.is_data ? frame_rdata_q : sinfo.cmd;
					result_q.is_data   <= sinfo.is_data;
					result_q.frame_end <= sinfo.last;
					state_q            <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/ptlr_checker.sv
// port-level checks for the proportional text line renderer, bound to the top level
// depends on ptlr_pkg, proportional_text_line_renderer
module ptlr_sva (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input ptlr_pkg::item_t   item,
	input logic              result_valid,
	input ptlr_pkg::result_t result
);
	import ptlr_pkg::*;

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a busy refresh step");

	a_refresh_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.operation == OP_REFRESH) |=> busy)
		else $error("refresh transfer did not raise busy");

	a_frame_end_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.frame_end) |-> result.is_data)
		else $error("frame end on a command byte");

endmodule

bind proportional_text_line_renderer ptlr_sva u_ptlr_sva (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.item         (item),
	.result_valid (result_valid),
	.result       (result)
);

// File: sim/ptlr_checker.sv
// checker for the proportional text line renderer: watches item and result transfers,
// keeps its own copy of the frame store, glyph store, line columns and stream position
// depends on ptlr_pkg
module ptlr_checker
	import ptlr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  logic    result_valid,
	input  result_t result,
	output int      errors,
	output int      pending
);

	localparam int STREAM_LEN = 4 * PAGE_SLOTS;

	bit [7:0] frame_px [FRAME_SIZE];
	bit [7:0] glyph_rom [GLYPH_SIZE];
	int       col_upper;
	int       col_lower;
	int       stream_pos;
	int       fails;
	result_t  panel_bytes_due [$];

	task automatic render_item(input item_t it);
		int code;
		int off;
		int col;
		int base;
		int page;
		int slot;
		result_t nxt;
		case (it.operation)
		OP_FONT: begin
			if (it.font_address < GLYPH_SIZE)
				glyph_rom[it.font_address] = it.font_byte;
		end
		OP_DRAW: begin
			code = it.char_code;
			if (code >= FIRST_CODE && code < FIRST_CODE + GLYPH_COUNT) begin
				off  = (code - FIRST_CODE) * GLYPH_BYTES;
				col  = it.text_line ? col_lower : col_upper;
				base = it.text_line ? 2 * PANEL_COLUMNS : 0;
				for (int i = 0; i < GLYPH_PAIRS; i++) begin
					if (col + i < PANEL_COLUMNS) begin
						frame_px[base + col + i] = glyph_rom[off + 2 * i + 1];
						frame_px[base + PANEL_COLUMNS + col + i] = glyph_rom[off + 2 * i + 2];
					end
				end
				col = col + glyph_rom[off];
				if (col > PANEL_COLUMNS)
					col = PANEL_COLUMNS;
				if (it.text_line)
					col_lower = col;
				else
					col_upper = col;
			end
		end
		OP_END: begin
			col  = it.text_line ? col_lower : col_upper;
			base = it.text_line ? 2 * PANEL_COLUMNS : 0;
			for (int c = col; c < PANEL_COLUMNS; c++) begin
				frame_px[base + c] = '0;
				frame_px[base + PANEL_COLUMNS + c] = '0;
			end
			if (it.text_line)
				col_lower = 0;
			else
				col_upper = 0;
		end
		default: begin
			page = stream_pos / PAGE_SLOTS;
			slot = stream_pos % PAGE_SLOTS;
			nxt.is_data = 1'b0;
			case (slot)
			0: nxt.out_byte = CMD_COL_LO;
			1: nxt.out_byte = CMD_COL_HI;
			2: nxt.out_byte = CMD_PAGE | 8'(page);
			default: begin
				nxt.out_byte = frame_px[page * PANEL_COLUMNS + slot - 3];
				nxt.is_data  = 1'b1;
			end
			endcase
			nxt.frame_end = (stream_pos == STREAM_LEN - 1);
			stream_pos = (stream_pos + 1) % STREAM_LEN;
			panel_bytes_due.push_back(nxt);
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t due;
		if (!arst_n) begin
			for (int i = 0; i < FRAME_SIZE; i++)
				frame_px[i] = '0;
			col_upper  = 0;
			col_lower  = 0;
			stream_pos = 0;
			fails      = 0;
			panel_bytes_due.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (start && !busy)
				render_item(item);
			if (result_valid) begin
				if (panel_bytes_due.size() == 0) begin
					$error("result transfer with nothing expected: out_byte %h", result.out_byte);
					fails++;
				end else begin
					due = panel_bytes_due.pop_front();
					if (result.out_byte !== due.out_byte) begin
						$error("out_byte: expected %h, got %h", due.out_byte, result.out_byte);
						fails++;
					end
					if (result.is_data !== due.is_data) begin
						$error("is_data: expected %b, got %b", due.is_data, result.is_data);
						fails++;
					end
					if (result.frame_end !== due.frame_end) begin
						$error("frame_end: expected %b, got %b", due.frame_end, result.frame_end);
						fails++;
					end
				end
			end
			errors  <= fails;
			pending <= panel_bytes_due.size();
		end
	end

endmodule

// File: sim/tb_top.sv
// testbench top for the proportional text line renderer: clock, reset, font loads,
// draws, line ends and refresh steps with random gaps; verdict from ptlr_checker
// depends on ptlr_pkg, ptlr_checker and the renderer rtl
module tb_top;
	import ptlr_pkg::*;

	localparam int STREAM_LEN = 4 * PAGE_SLOTS;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    result_valid;
	result_t result;
	int      errors;
	int      pending;

	int idle_pct;
	bit font_set [GLYPH_SIZE];
	bit glyph_listed [GLYPH_COUNT];
	int loaded_glyphs [$];
	int n_items, n_font, n_draw, n_end, n_refresh;
	int stream_pos;

	always #2 clk = ~clk;

	proportional_text_line_renderer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	ptlr_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.errors       (errors),
		.pending      (pending)
	);

	function automatic bit glyph_complete(input int g);
		for (int i = 0; i < GLYPH_BYTES; i++)
			if (!font_set[g * GLYPH_BYTES + i])
				return 1'b0;
		return 1'b1;
	endfunction

	// codes outside the font now and then, otherwise a fully loaded glyph
	function automatic logic [7:0] pick_code();
		if ($urandom_range(99) < 12 || loaded_glyphs.size() == 0) begin
			if ($urandom_range(1))
				return 8'($urandom_range(FIRST_CODE - 1));
			return 8'($urandom_range(255, FIRST_CODE + GLYPH_COUNT));
		end
		return FIRST_CODE + 8'(loaded_glyphs[$urandom_range(loaded_glyphs.size() - 1)]);
	endfunction

	task automatic issue(input logic [1:0] op, input logic line, input logic [7:0] code,
			input logic [11:0] addr, input logic [7:0] fbyte);
		item_t it;
		int g;
		it = '{operation: op, text_line: line, char_code: code,
			font_address: addr, font_byte: fbyte};
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		n_items++;
		case (op)
		OP_FONT: begin
			n_font++;
			if (addr < GLYPH_SIZE) begin
				font_set[addr] = 1'b1;
				g = addr / GLYPH_BYTES;
				if (!glyph_listed[g] && glyph_complete(g)) begin
					glyph_listed[g] = 1'b1;
					loaded_glyphs.push_back(g);
				end
			end
		end
		OP_DRAW: n_draw++;
		OP_END:  n_end++;
		default: begin
			n_refresh++;
			stream_pos = (stream_pos + 1) % STREAM_LEN;
		end
		endcase
	endtask

	task automatic font_write(input logic [11:0] addr, input logic [7:0] fbyte);
		issue(OP_FONT, 1'($urandom), 8'($urandom), addr, fbyte);
	endtask

	task automatic draw(input logic line, input logic [7:0] code);
		issue(OP_DRAW, line, code, 12'($urandom), 8'($urandom));
	endtask

	task automatic end_line(input logic line);
		issue(OP_END, line, 8'($urandom), 12'($urandom), 8'($urandom));
	endtask

	task automatic refresh();
		issue(OP_REFRESH, 1'($urandom), 8'($urandom), 12'($urandom), 8'($urandom));
	endtask

	task automatic load_glyph(input int g, input logic [7:0] width);
		font_write(12'(g * GLYPH_BYTES), width);
		for (int i = 1; i < GLYPH_BYTES; i++)
			font_write(12'(g * GLYPH_BYTES + i), 8'($urandom));
	endtask

	initial begin
		#12_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		int r;
		int quota;
		arst_n   <= 1'b0;
		start    <= 1'b0;
		item     <= '0;
		idle_pct = 14;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// glyphs for the edge cases: wide, saturating, zero width, ordinary
		load_glyph(GLYPH_COUNT - 1, 8'd120);
		load_glyph(0, 8'd255);
		load_glyph(33, 8'd0);
		load_glyph(8, 8'd7);

		font_write(12'(GLYPH_SIZE), 8'hFF);
		font_write(12'hFFF, 8'h00);
		repeat (3) refresh();
		draw(1'b0, FIRST_CODE + 8'(GLYPH_COUNT - 1));
		draw(1'b0, FIRST_CODE + 8'(GLYPH_COUNT - 1));
		draw(1'b0, FIRST_CODE);
		end_line(1'b0);
		draw(1'b1, FIRST_CODE + 8'd33);
		draw(1'b1, FIRST_CODE);
		draw(1'b0, 8'h00);
		draw(1'b0, FIRST_CODE - 8'd1);
		draw(1'b0, FIRST_CODE + 8'(GLYPH_COUNT));
		draw(1'b0, 8'hFF);
		draw(1'b0, FIRST_CODE + 8'd8);
		end_line(1'b0);
		end_line(1'b1);
		repeat (4) refresh();

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 14 : (phase == 1) ? 69 : 0;
			quota = n_items + 250;
			while (n_items < quota) begin
				r = $urandom_range(99);
				if (r < 6)
					load_glyph($urandom_range(GLYPH_COUNT - 1),
						($urandom_range(99) < 80) ? 8'($urandom_range(14, 1)) : 8'($urandom));
				else if (r < 16)
					font_write(12'($urandom), 8'($urandom));
				else if (r < 46)
					draw(1'($urandom), pick_code());
				else if (r < 53)
					end_line(1'($urandom));
				else
					refresh();
			end
		end

		// finish the frame so the last byte of a frame is always seen
		while (stream_pos != 0)
			refresh();
		start <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		$display("tb_top: %0d transfers: %0d font writes, %0d draws, %0d line ends, %0d refreshes",
			n_items, n_font, n_draw, n_end, n_refresh);
		$display("tb_top: %0d full frames streamed, %0d glyphs fully loaded",
			n_refresh / STREAM_LEN, loaded_glyphs.size());
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
rtl/ptlr_pkg.sv
rtl/ptlr_stream.sv
rtl/proportional_text_line_renderer.sv
rtl/ptlr_checker.sv
sim/ptlr_checker.sv
sim/tb_top.sv
